>>> sv/rtp_hsp_pkg.sv
package rtp_hsp_pkg;

   // result kinds carried on rsp_tuser
   localparam logic [2:0] KIND_FIXED = 3'd0;
   localparam logic [2:0] KIND_CSRC  = 3'd1;
   localparam logic [2:0] KIND_EXTH  = 3'd2;
   localparam logic [2:0] KIND_EXTW  = 3'd3;
   localparam logic [2:0] KIND_BAD   = 3'd4;
   localparam logic [2:0] KIND_TRUNC = 3'd5;

   localparam int unsigned KIND_W     = 3;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 176;   // 173 field bits, padded to bytes

   // default depth of the queue between parser and output stage
   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   // which group of fields a queued result fills
   typedef enum logic [1:0] {
      FMT_NONE = 2'd0,
      FMT_HDR  = 2'd1,
      FMT_WORD = 2'd2,
      FMT_EXT  = 2'd3
   } fmt_type;

   // compact result record held in the queue
   typedef struct packed {
      logic [2:0]  kind;
      fmt_type     fmt;
      logic        marker;
      logic [6:0]  ptype;
      logic [15:0] sequence_nr;
      logic [31:0] timestamp;
      logic [31:0] word;       // ssrc, csrc, ext header or ext data word
      logic [15:0] index;
      logic [3:0]  csrc_count;
      logic        has_ext;
   } rslt_type;

endpackage

>>> sv/rtp_hsp_front.sv
module rtp_hsp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   output logic                   res_valid,
   output rtp_hsp_pkg::rslt_type  res
);

   // section of the packet being parsed
   typedef enum logic [4:0] {
      PH_FIXED   = 5'b00001,
      PH_CSRC    = 5'b00010,
      PH_EXTH    = 5'b00100,
      PH_EXTW    = 5'b01000,
      PH_PAYLOAD = 5'b10000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  pos_ff, pos_in;
   logic [31:0] word_shift_ff, word_shift_in;
   logic [3:0]  csrc_left_ff, csrc_left_in;
   logic [15:0] ext_left_ff, ext_left_in;
   logic [15:0] list_index_ff, list_index_in;
   logic        ext_flag_ff, ext_flag_in;
   logic        marker_ff, marker_in;
   logic [6:0]  ptype_ff, ptype_in;
   logic [15:0] seq_ff, seq_in;
   logic [31:0] ts_ff, ts_in;
   logic        skip_ff, skip_in;

   logic [31:0] ws_new;
   logic [3:0]  csrc_dec;
   logic [15:0] ext_dec;
   phase_type   next_ph;
   logic        trunc, clr, fin, bad;

   // per-byte parse step
   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      word_shift_in = word_shift_ff;
      csrc_left_in  = csrc_left_ff;
      ext_left_in   = ext_left_ff;
      list_index_in = list_index_ff;
      ext_flag_in   = ext_flag_ff;
      marker_in     = marker_ff;
      ptype_in      = ptype_ff;
      seq_in        = seq_ff;
      ts_in         = ts_ff;
      skip_in       = skip_ff;
      res_valid     = 1'b0;
      res           = '0;
      res.fmt       = rtp_hsp_pkg::FMT_NONE;
      trunc         = 1'b0;
      clr           = 1'b0;
      fin           = 1'b0;
      bad           = 1'b0;
      next_ph       = PH_PAYLOAD;
      ws_new        = {word_shift_ff[23:0], data_byte};
      csrc_dec      = csrc_left_ff - 4'd1;
      ext_dec       = ext_left_ff - 16'd1;

      if (skip_ff) begin
         // drop the rest of a rejected packet
         if (last_byte) clr = 1'b1;
      end else begin
         word_shift_in = ws_new;
         unique case (phase_ff)
            PH_FIXED: begin
               if (pos_ff == 4'd0) begin
                  csrc_left_in = data_byte[3:0];
                  ext_flag_in  = data_byte[4];
               end else if (pos_ff == 4'd1) begin
                  marker_in = data_byte[7];
                  ptype_in  = data_byte[6:0];
                  if (last_byte) begin
                     trunc = 1'b1;
                  end else if (ws_new[15:14] != 2'd2 || data_byte[6:0] == 7'd0) begin
                     bad       = 1'b1;
                     res_valid = 1'b1;
                     res.kind  = rtp_hsp_pkg::KIND_BAD;
                     skip_in   = 1'b1;
                  end
               end else if (pos_ff == 4'd3) begin
                  seq_in = ws_new[15:0];
               end else if (pos_ff == 4'd7) begin
                  ts_in = ws_new;
               end
               if (!trunc && !bad) begin
                  if (pos_ff < 4'd11) begin
                     if (last_byte) trunc = 1'b1;
                     else pos_in = pos_ff + 4'd1;
                  end else begin
                     res.kind        = rtp_hsp_pkg::KIND_FIXED;
                     res.fmt         = rtp_hsp_pkg::FMT_HDR;
                     res.marker      = marker_ff;
                     res.ptype       = ptype_ff;
                     res.sequence_nr = seq_ff;
                     res.timestamp   = ts_ff;
                     res.word        = ws_new;
                     res.csrc_count  = csrc_left_ff;
                     res.has_ext     = ext_flag_ff;
                     list_index_in   = 16'd0;
                     if (csrc_left_ff != 4'd0) next_ph = PH_CSRC;
                     else if (ext_flag_ff) next_ph = PH_EXTH;
                     else next_ph = PH_PAYLOAD;
                     fin = 1'b1;
                  end
               end
            end
            PH_CSRC, PH_EXTH, PH_EXTW: begin
               if (pos_ff < 4'd3) begin
                  if (last_byte) trunc = 1'b1;
                  else pos_in = pos_ff + 4'd1;
               end else begin
                  fin = 1'b1;
                  if (phase_ff == PH_CSRC) begin
                     res.kind      = rtp_hsp_pkg::KIND_CSRC;
                     res.fmt       = rtp_hsp_pkg::FMT_WORD;
                     res.word      = ws_new;
                     res.index     = list_index_ff;
                     csrc_left_in  = csrc_dec;
                     list_index_in = list_index_ff + 16'd1;
                     if (csrc_dec != 4'd0) begin
                        next_ph = PH_CSRC;
                     end else begin
                        list_index_in = 16'd0;
                        next_ph = ext_flag_ff ? PH_EXTH : PH_PAYLOAD;
                     end
                  end else if (phase_ff == PH_EXTH) begin
                     res.kind      = rtp_hsp_pkg::KIND_EXTH;
                     res.fmt       = rtp_hsp_pkg::FMT_EXT;
                     res.word      = ws_new;
                     ext_left_in   = ws_new[15:0];
                     list_index_in = 16'd0;
                     next_ph = (ws_new[15:0] != 16'd0) ? PH_EXTW : PH_PAYLOAD;
                  end else begin
                     res.kind      = rtp_hsp_pkg::KIND_EXTW;
                     res.fmt       = rtp_hsp_pkg::FMT_WORD;
                     res.word      = ws_new;
                     res.index     = list_index_ff;
                     ext_left_in   = ext_dec;
                     list_index_in = list_index_ff + 16'd1;
                     next_ph = (ext_dec != 16'd0) ? PH_EXTW : PH_PAYLOAD;
                  end
               end
            end
            default: begin
               // payload bytes: no result
               if (last_byte) clr = 1'b1;
            end
         endcase

         // section done: move on, or flag a header cut short
         if (fin) begin
            res_valid = 1'b1;
            if (last_byte && next_ph != PH_PAYLOAD) begin
               trunc = 1'b1;
            end else begin
               phase_in = next_ph;
               pos_in   = 4'd0;
               if (last_byte) clr = 1'b1;
            end
         end
         // truncation keeps any fields already filled in
         if (trunc) begin
            res_valid = 1'b1;
            res.kind  = rtp_hsp_pkg::KIND_TRUNC;
            clr       = 1'b1;
         end
      end

      // end of packet: back to the start state
      if (clr) begin
         phase_in      = PH_FIXED;
         pos_in        = 4'd0;
         word_shift_in = 32'd0;
         csrc_left_in  = 4'd0;
         ext_left_in   = 16'd0;
         list_index_in = 16'd0;
         ext_flag_in   = 1'b0;
         marker_in     = 1'b0;
         ptype_in      = 7'd0;
         seq_in        = 16'd0;
         ts_in         = 32'd0;
         skip_in       = 1'b0;
      end
   end

   // parser state, advanced once per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FIXED;
         pos_ff        <= 4'd0;
         word_shift_ff <= 32'd0;
         csrc_left_ff  <= 4'd0;
         ext_left_ff   <= 16'd0;
         list_index_ff <= 16'd0;
         ext_flag_ff   <= 1'b0;
         marker_ff     <= 1'b0;
         ptype_ff      <= 7'd0;
         seq_ff        <= 16'd0;
         ts_ff         <= 32'd0;
         skip_ff       <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         word_shift_ff <= word_shift_in;
         csrc_left_ff  <= csrc_left_in;
         ext_left_ff   <= ext_left_in;
         list_index_ff <= list_index_in;
         ext_flag_ff   <= ext_flag_in;
         marker_ff     <= marker_in;
         ptype_ff      <= ptype_in;
         seq_ff        <= seq_in;
         ts_ff         <= ts_in;
         skip_ff       <= skip_in;
      end
   end

   // a rejected packet is only ever skipped from the fixed header
   a_skip_in_fixed: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> (phase_ff == PH_FIXED && pos_ff == 4'd1))
      else $error("skip set outside the fixed header");

   a_bad_sets_skip: assert property (@(posedge clock) disable iff (reset)
      (accept && res_valid && res.kind == rtp_hsp_pkg::KIND_BAD) |=> skip_ff)
      else $error("bad header did not start skipping");

endmodule

>>> sv/rtp_hsp_queue.sv
module rtp_hsp_queue #(
   parameter int unsigned DEPTH = rtp_hsp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rtp_hsp_pkg::rslt_type  push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   not_empty,
   output rtp_hsp_pkg::rslt_type  head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   rtp_hsp_pkg::rslt_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count past depth");

endmodule

>>> sv/rtp_hsp_back.sv
module rtp_hsp_back (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    q_not_empty,
   input  rtp_hsp_pkg::rslt_type                   q_head,
   output logic                                    q_pop,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [rtp_hsp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [rtp_hsp_pkg::KIND_W-1:0]          rsp_tuser
);

   logic                                rsp_valid_ff;
   logic [rtp_hsp_pkg::KIND_W-1:0]      kind_ff;
   logic [rtp_hsp_pkg::RSP_DATA_W-1:0]  data_ff, data_in;

   logic        f_marker;
   logic [6:0]  f_ptype;
   logic [15:0] f_seq;
   logic [31:0] f_ts;
   logic [31:0] f_ssrc;
   logic [3:0]  f_cc;
   logic        f_x;
   logic [31:0] f_word;
   logic [15:0] f_index;
   logic [15:0] f_profile;
   logic [15:0] f_length;

   // take the next result when the output register is free or draining
   assign q_pop = q_not_empty && (!rsp_valid_ff || rsp_tready);

   // spread the queued record onto the fields of its group
   always_comb begin
      f_marker  = 1'b0;
      f_ptype   = 7'd0;
      f_seq     = 16'd0;
      f_ts      = 32'd0;
      f_ssrc    = 32'd0;
      f_cc      = 4'd0;
      f_x       = 1'b0;
      f_word    = 32'd0;
      f_index   = 16'd0;
      f_profile = 16'd0;
      f_length  = 16'd0;
      unique case (q_head.fmt)
         rtp_hsp_pkg::FMT_HDR: begin
            f_marker = q_head.marker;
            f_ptype  = q_head.ptype;
            f_seq    = q_head.sequence_nr;
            f_ts     = q_head.timestamp;
            f_ssrc   = q_head.word;
            f_cc     = q_head.csrc_count;
            f_x      = q_head.has_ext;
         end
         rtp_hsp_pkg::FMT_WORD: begin
            f_word  = q_head.word;
            f_index = q_head.index;
         end
         rtp_hsp_pkg::FMT_EXT: begin
            f_profile = q_head.word[31:16];
            f_length  = q_head.word[15:0];
         end
         rtp_hsp_pkg::FMT_NONE: begin
         end
      endcase
      data_in = {3'd0, f_length, f_profile, f_index, f_word, f_x, f_cc,
                 f_ssrc, f_ts, f_seq, f_ptype, f_marker};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         kind_ff <= q_head.kind;
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;

   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid_ff)
      else $error("popped result not presented");

endmodule

>>> sv/rtp_header_stream_parser.sv
// Channel | Dir | Ports                     | Beat contents
// req     | in  | req_tvalid/tready/tdata/  | tdata: packet byte; tlast: final byte
//         |     | tlast                     |
// rsp     | out | rsp_tvalid/tready/tdata/  | tuser: result kind; tdata: header,
//         |     | tuser                     | list word or extension fields
//
// One packet byte is taken per clock while req_tready is high; a byte's result,
// if any, is written into the queue at its beat and then loaded into the output
// register once that is free or draining, which puts it on rsp.
// Synchronous active-high reset puts the parser at the start of a packet and
// empties the queue; no clearing pass.
// req_tready drops only while the result queue is full, i.e. rsp has been
// stalled for QUEUE_DEPTH results in a row behind the output register.
module rtp_header_stream_parser #(
   parameter int unsigned QUEUE_DEPTH = rtp_hsp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [rtp_hsp_pkg::REQ_DATA_W-1:0]   req_tdata,   // [7:0] data_byte
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] marker, [7:1] payload_type, [23:8] sequence_res, [55:24] timestamp,
   // [87:56] source_id, [91:88] csrc_count, [92] has_extension, [124:93] word,
   // [140:125] word_index, [156:141] ext_profile, [172:157] ext_length, rest 0
   output logic [rtp_hsp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [rtp_hsp_pkg::KIND_W-1:0]       rsp_tuser    // [2:0] kind
);

   logic                  accept;
   logic                  res_valid;
   rtp_hsp_pkg::rslt_type res;
   logic                  q_full;
   logic                  q_not_empty;
   logic                  q_pop;
   rtp_hsp_pkg::rslt_type q_head;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   rtp_hsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .res_valid (res_valid),
      .res       (res)
   );

   rtp_hsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && res_valid),
      .push_data (res),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   rtp_hsp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

>>> dv/rtp_header_stream_parser_test.sv
`timescale 1ns / 100ps

// rsp_tdata split into its fields, highest bits first
typedef struct packed {
   logic [2:0]  pad;
   logic [15:0] ext_length;
   logic [15:0] ext_profile;
   logic [15:0] word_index;
   logic [31:0] word;
   logic        has_extension;
   logic [3:0]  csrc_count;
   logic [31:0] source_id;
   logic [31:0] timestamp;
   logic [15:0] sequence_res;
   logic [6:0]  payload_type;
   logic        marker;
} rsp_fields_type;

typedef struct {
   logic [2:0]     kind;
   rsp_fields_type f;
} rtp_result_type;

// header section the parser is in
typedef enum logic [2:0] {
   SEC_FIXED   = 3'd0,
   SEC_CSRC    = 3'd1,
   SEC_EXTH    = 3'd2,
   SEC_EXTW    = 3'd3,
   SEC_PAYLOAD = 3'd4
} section_type;

// Header parser model plus the queue of results it has parsed but not yet seen
class rtp_field_scoreboard;
   rtp_result_type parsed_due[$];
   int             mismatches;

   section_type section;
   logic [3:0]  byte_pos;
   logic [31:0] shift_word;
   logic [3:0]  csrc_left;
   logic [15:0] ext_left;
   logic [15:0] list_idx;
   logic        ext_flag;
   logic        hold_marker;
   logic [6:0]  hold_type;
   logic [15:0] hold_seq;
   logic [31:0] hold_ts;
   logic        skip_rest;

   function new();
      mismatches = 0;
      clear_parser();
   endfunction

   function void clear_parser();
      section     = SEC_FIXED;
      byte_pos    = '0;
      shift_word  = '0;
      csrc_left   = '0;
      ext_left    = '0;
      list_idx    = '0;
      ext_flag    = 1'b0;
      hold_marker = 1'b0;
      hold_type   = '0;
      hold_seq    = '0;
      hold_ts     = '0;
      skip_rest   = 1'b0;
   endfunction

   function int pending();
      return parsed_due.size();
   endfunction

   // truncation keeps whatever fields the replaced result had
   function void truncate(rtp_result_type r);
      r.kind = rtp_hsp_pkg::KIND_TRUNC;
      clear_parser();
      parsed_due.push_back(r);
   endfunction

   function void close_section(section_type nxt, logic last, rtp_result_type r);
      if (last && nxt != SEC_PAYLOAD) begin
         truncate(r);
         return;
      end
      section  = nxt;
      byte_pos = '0;
      if (last)
         clear_parser();
      parsed_due.push_back(r);
   endfunction

   // advance the parser by one accepted byte
   function void parse_byte(logic [7:0] b, logic last);
      rtp_result_type r;
      section_type    nxt;
      logic [3:0]     pos;
      r.kind = '0;
      r.f    = '0;
      pos    = byte_pos;
      if (skip_rest) begin
         if (last)
            clear_parser();
         return;
      end
      shift_word = {shift_word[23:0], b};
      case (section)
         SEC_FIXED: begin
            if (pos == 4'd0) begin
               csrc_left = b[3:0];
               ext_flag  = b[4];
            end else if (pos == 4'd1) begin
               hold_marker = b[7];
               hold_type   = b[6:0];
               if (last) begin
                  truncate(r);
                  return;
               end
               // version must be 2 and payload type nonzero
               if (shift_word[15:14] != 2'd2 || hold_type == 7'd0) begin
                  r.kind = rtp_hsp_pkg::KIND_BAD;
                  skip_rest = 1'b1;
                  parsed_due.push_back(r);
                  return;
               end
            end else if (pos == 4'd3) begin
               hold_seq = shift_word[15:0];
            end else if (pos == 4'd7) begin
               hold_ts = shift_word;
            end
            if (pos < 4'd11) begin
               if (last) begin
                  truncate(r);
                  return;
               end
               byte_pos = pos + 4'd1;
               return;
            end
            r.kind            = rtp_hsp_pkg::KIND_FIXED;
            r.f.marker        = hold_marker;
            r.f.payload_type  = hold_type;
            r.f.sequence_res  = hold_seq;
            r.f.timestamp     = hold_ts;
            r.f.source_id     = shift_word;
            r.f.csrc_count    = csrc_left;
            r.f.has_extension = ext_flag;
            list_idx = '0;
            nxt = (csrc_left != 0) ? SEC_CSRC : (ext_flag ? SEC_EXTH : SEC_PAYLOAD);
            close_section(nxt, last, r);
         end
         SEC_CSRC, SEC_EXTH, SEC_EXTW: begin
            if (pos < 4'd3) begin
               if (last) begin
                  truncate(r);
                  return;
               end
               byte_pos = pos + 4'd1;
               return;
            end
            if (section == SEC_CSRC) begin
               r.kind         = rtp_hsp_pkg::KIND_CSRC;
               r.f.word       = shift_word;
               r.f.word_index = list_idx;
               csrc_left = csrc_left - 4'd1;
               list_idx  = list_idx + 16'd1;
               if (csrc_left != 0) begin
                  nxt = SEC_CSRC;
               end else begin
                  list_idx = '0;
                  nxt = ext_flag ? SEC_EXTH : SEC_PAYLOAD;
               end
            end else if (section == SEC_EXTH) begin
               r.kind          = rtp_hsp_pkg::KIND_EXTH;
               r.f.ext_profile = shift_word[31:16];
               r.f.ext_length  = shift_word[15:0];
               ext_left = shift_word[15:0];
               list_idx = '0;
               nxt = (ext_left != 0) ? SEC_EXTW : SEC_PAYLOAD;
            end else begin
               r.kind         = rtp_hsp_pkg::KIND_EXTW;
               r.f.word       = shift_word;
               r.f.word_index = list_idx;
               ext_left = ext_left - 16'd1;
               list_idx = list_idx + 16'd1;
               nxt = (ext_left != 0) ? SEC_EXTW : SEC_PAYLOAD;
            end
            close_section(nxt, last, r);
         end
         default: begin
            if (last)
               clear_parser();
         end
      endcase
   endfunction

   task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
   endtask

   task cmp(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report($sformatf("%s got %h expected %h", name, got, want));
   endtask

   // compare one rsp beat against the oldest parsed result
   task check_beat(logic [rtp_hsp_pkg::RSP_DATA_W-1:0] data,
                   logic [rtp_hsp_pkg::KIND_W-1:0] kind);
      rtp_result_type want;
      rsp_fields_type got;
      if (parsed_due.size() == 0) begin
         report($sformatf("result beat with nothing due, kind %0d", kind));
         return;
      end
      want = parsed_due.pop_front();
      got  = rsp_fields_type'(data);
      cmp("kind", kind, want.kind);
      cmp("marker", got.marker, want.f.marker);
      cmp("payload_type", got.payload_type, want.f.payload_type);
      cmp("sequence_res", got.sequence_res, want.f.sequence_res);
      cmp("timestamp", got.timestamp, want.f.timestamp);
      cmp("source_id", got.source_id, want.f.source_id);
      cmp("csrc_count", got.csrc_count, want.f.csrc_count);
      cmp("has_extension", got.has_extension, want.f.has_extension);
      cmp("word", got.word, want.f.word);
      cmp("word_index", got.word_index, want.f.word_index);
      cmp("ext_profile", got.ext_profile, want.f.ext_profile);
      cmp("ext_length", got.ext_length, want.f.ext_length);
      cmp("pad", got.pad, want.f.pad);
   endtask
endclass

module rtp_header_stream_parser_test;

   localparam int BYTE_TARGET = 1150;

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [rtp_hsp_pkg::REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                                req_tlast  = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [rtp_hsp_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic [rtp_hsp_pkg::KIND_W-1:0]      rsp_tuser;

   rtp_field_scoreboard parser_sb = new();

   int          send_idle  = 0;
   int          recv_stall = 0;
   int          bytes_sent = 0;
   logic [7:0]  pkt[$];

   rtp_header_stream_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         parser_sb.check_beat(rsp_tdata, rsp_tuser);
   end

   // one byte beat; called and returns at a falling edge
   task automatic push_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      parser_sb.parse_byte(b, last);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_pkt();
      for (int i = 0; i < pkt.size(); i++)
         push_byte(pkt[i], i == pkt.size() - 1);
   endtask

   task automatic add_word(input logic [31:0] w);
      pkt.push_back(w[31:24]);
      pkt.push_back(w[23:16]);
      pkt.push_back(w[15:8]);
      pkt.push_back(w[7:0]);
   endtask

   // a well-formed header with random content, sometimes cut short
   task automatic build_rtp();
      logic [3:0]  cc;
      logic        x;
      logic [15:0] ext_len;
      int          ext_words;
      int          hdr_len;
      bit          cut;
      cc = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
      x  = 1'($urandom_range(1));
      pkt.delete();
      pkt.push_back({2'b10, 1'($urandom_range(1)), x, cc});
      pkt.push_back({1'($urandom_range(1)), 7'($urandom_range(127, 1))});
      pkt.push_back(8'($urandom));
      pkt.push_back(8'($urandom));
      add_word($urandom);
      add_word($urandom);
      for (int i = 0; i < cc; i++)
         add_word($urandom);
      cut = ($urandom_range(6) == 0);
      if (x) begin
         // a huge length is only ever sent truncated
         if ($urandom_range(14) == 0) begin
            ext_len = ($urandom_range(1)) ? 16'hffff : 16'($urandom);
            ext_words = $urandom_range(3);
            cut = 1'b1;
         end else begin
            ext_len = 16'($urandom_range(3));
            ext_words = ext_len;
         end
         add_word({16'($urandom), ext_len});
         for (int i = 0; i < ext_words; i++)
            add_word($urandom);
      end
      hdr_len = pkt.size();
      if (cut) begin
         hdr_len = $urandom_range(hdr_len, 1);
         while (pkt.size() > hdr_len)
            void'(pkt.pop_back());
      end else begin
         for (int i = $urandom_range(8); i > 0; i--)
            pkt.push_back(8'($urandom));
      end
   endtask

   // random bytes, usually with a bad version or a zero payload type
   task automatic build_noise();
      int n;
      n = $urandom_range(20, 1);
      pkt.delete();
      for (int i = 0; i < n; i++)
         pkt.push_back(8'($urandom));
      if (n > 1 && $urandom_range(1))
         pkt[1][6:0] = 7'd0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: truncated at the first and second byte
      pkt = '{8'h80};
      send_pkt();
      pkt = '{8'h80, 8'h60};
      send_pkt();
      // bad version, then a zero payload type with marker set
      pkt = '{8'h40, 8'h60, 8'h00};
      send_pkt();
      pkt = '{8'h80, 8'h80, 8'haa};
      send_pkt();
      // fixed header, all ones after the first byte, ending on its last byte
      pkt = '{8'ha0, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
              8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
      send_pkt();

      // random packets over four idling phases
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 88; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 88; end
            default: begin send_idle = 38; recv_stall = 38; end
         endcase
         while (bytes_sent < (ph + 1) * BYTE_TARGET / 4) begin
            if ($urandom_range(3) == 0)
               build_noise();
            else
               build_rtp();
            send_pkt();
         end
      end

      // drain
      req_tvalid <= 1'b0;
      send_idle  = 0;
      recv_stall = 0;
      while (parser_sb.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (parser_sb.mismatches == 0 && parser_sb.pending() == 0)
         $display("rtp_header_stream_parser test passed");
      else
         $display("rtp_header_stream_parser test failed");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("rtp_header_stream_parser test failed");
      $finish;
   end

endmodule
